// ===== sv/linear_blend_skinning_top_assert.svh =====
// Assertion macros for the skinning block.
`ifndef LINEAR_BLEND_SKINNING_TOP_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lbs_pkg.sv =====
`default_nettype none
package lbs_pkg;
    localparam int MaxBones   = 64;
    localparam int ValueWidth = 32;
    localparam int BoneW      = $clog2(MaxBones);
    localparam int AddrW      = BoneW + 2;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0, K_INFL = 2'd1, K_PASS = 2'd2, K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_DOT, S_ACC, S_OUT
    } t_state;

    typedef struct packed {
        logic       load;      // capture input item
        logic       rd;        // read palette row
        logic       dot;       // dot product stage
        logic       acc;       // weight and accumulate row term
        logic       emit_sum;  // move sum to output
        logic       emit_vec;  // move vector to output
        logic       clr;       // clear sums
        logic [1:0] row;
    } t_cmd;

    function automatic logic signed [63:0] floor16(input logic signed [95:0] x);
        floor16 = 64'(x >>> 16);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (ValueWidth - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi) sat32 = 32'(hi);
        else if (x < lo) sat32 = 32'(lo);
        else sat32 = 32'(x);
    endfunction
endpackage
`default_nettype wire

// ===== sv/lbs_if.sv =====
`default_nettype none
interface lbs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  bone;
    logic [1:0]  row;
    logic signed [31:0] a_x, a_y, a_z, a_w;
    logic [16:0] weight;
    logic        last_influence;
    modport source (output valid, kind, bone, row, a_x, a_y, a_z, a_w, weight,
                    last_influence, input ready);
    modport sink (input valid, kind, bone, row, a_x, a_y, a_z, a_w, weight,
                  last_influence, output ready);
endinterface

interface lbs_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    modport source (output valid, out_x, out_y, out_z, out_w, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface
`default_nettype wire

// ===== sv/lbs_ctrl.sv =====
`default_nettype none
module lbs_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_last,
    input  wire logic        i_out_busy,
    output lbs_pkg::t_cmd    o_cmd
);
    lbs_pkg::t_state r_state, n_state;
    logic [1:0] r_row, n_row;
    logic r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbs_pkg::S_IDLE;
            r_row   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_last  = r_last;
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.row = r_row;
        case (r_state)
            lbs_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_last = 1'b0;
                    n_row  = '0;
                    case (lbs_pkg::t_kind'(i_kind))
                        lbs_pkg::K_INFL: begin
                            n_last  = i_last;
                            n_state = lbs_pkg::S_READ;
                        end
                        lbs_pkg::K_PASS: n_state = lbs_pkg::S_OUT;
                        default:         n_state = lbs_pkg::S_IDLE;
                    endcase
                end
            end
            lbs_pkg::S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = lbs_pkg::S_DOT;
            end
            lbs_pkg::S_DOT: begin
                o_cmd.dot = 1'b1;
                n_state   = lbs_pkg::S_ACC;
            end
            lbs_pkg::S_ACC: begin
                o_cmd.acc = 1'b1;
                n_row = r_row + 2'd1;
                if (r_row == 2'd3) begin
                    n_state = r_last ? lbs_pkg::S_OUT : lbs_pkg::S_IDLE;
                end else begin
                    n_state = lbs_pkg::S_READ;
                end
            end
            lbs_pkg::S_OUT: begin
                if (!i_out_busy) begin
                    o_cmd.emit_sum = r_last;
                    o_cmd.emit_vec = !r_last;
                    o_cmd.clr      = r_last;
                    n_last  = 1'b0;
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            default: n_state = lbs_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/lbs_dp.sv =====
`default_nettype none
module lbs_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lbs_pkg::t_cmd      i_cmd,
    input  wire logic [1:0]         i_kind,
    input  wire logic [5:0]         i_bone,
    input  wire logic [1:0]         i_row,
    input  wire logic signed [31:0] i_a_x, i_a_y, i_a_z, i_a_w,
    input  wire logic [16:0]        i_weight,
    output logic signed [31:0]      o_res [4],
    output logic                    o_res_load
);
    logic [127:0] r_mem [lbs_pkg::MaxBones*4];
    logic [127:0] r_rd;
    logic signed [31:0] r_v [4];
    logic [lbs_pkg::BoneW-1:0] r_slot;
    logic [16:0] r_w;
    logic signed [31:0] r_dot;
    logic signed [63:0] r_sum [4];
    logic [lbs_pkg::AddrW-1:0] wr_addr;
    logic signed [63:0] mul [4];
    logic signed [63:0] prod [4];
    logic signed [63:0] dot;
    logic signed [31:0] dsat;
    logic signed [49:0] wprod;
    logic signed [63:0] term;
    logic signed [64:0] s;

    assign wr_addr = {lbs_pkg::BoneW'(i_bone), i_row};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && lbs_pkg::t_kind'(i_kind) == lbs_pkg::K_LOAD) begin
            r_mem[wr_addr] <= {i_a_w, i_a_z, i_a_y, i_a_x};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[{r_slot, i_cmd.row}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v[0] <= i_a_x; r_v[1] <= i_a_y; r_v[2] <= i_a_z; r_v[3] <= i_a_w;
            r_slot <= lbs_pkg::BoneW'(i_bone);
            r_w    <= i_weight;
        end
    end

    // Four column products, floored, summed and saturated.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            mul[c]  = $signed(r_rd[c*32 +: 32]) * r_v[c];
            prod[c] = lbs_pkg::floor16(96'(mul[c]));
        end
        dot  = prod[0] + prod[1] + prod[2] + prod[3];
        dsat = lbs_pkg::sat32(dot);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dot) begin
            r_dot <= dsat;
        end
    end

    // Weight the held dot product in the accumulate step.
    always_comb begin
        wprod = r_dot * $signed({1'b0, r_w});
        term  = lbs_pkg::floor16(96'(wprod));
    end

    assign s = 65'(r_sum[i_cmd.row]) + 65'(term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int i = 0; i < 4; i++) r_sum[i] <= '0;
        end else if (i_cmd.acc) begin
            if (s[64] != s[63]) begin
                r_sum[i_cmd.row] <= s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end else begin
                r_sum[i_cmd.row] <= s[63:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_res[i] = i_cmd.emit_sum ? lbs_pkg::sat32(r_sum[i])
                                      : lbs_pkg::sat32(64'(r_v[i]));
        end
        o_res_load = i_cmd.emit_sum || i_cmd.emit_vec;
    end
endmodule
`default_nettype wire

// ===== sv/linear_blend_skinning_top.sv =====
// Linear blend skinning unit, Q16.16 fixed point.
// Input channel i_in carries load, influence and passthrough items; output
// channel o_out carries one skinned vector per finished vertex and one per passthrough item.
// A load item writes one palette row and leaves the block idle. An influence item
// runs, per matrix row, one palette read, one dot-product stage and one
// weighting and accumulate step; the single palette read port serialises the rows.
// A passthrough item or the last influence then passes through an output step
// that moves its result into the output register. Items are taken one at a time.
// The output register holds a result until the receiver takes it; a
// stalled receiver holds the block in its output step while the register
// is still full, and the block keeps accepting meanwhile otherwise.
// Reset clears the controller and the accumulators; the palette is not
// cleared and must be loaded before use.
`default_nettype none
`include "linear_blend_skinning_top_assert.svh"
module linear_blend_skinning_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lbs_in_if.sink      i_in,
    lbs_out_if.source   o_out
);
    lbs_pkg::t_cmd cmd;
    logic signed [31:0] res [4];
    logic res_load;
    logic r_ovalid;
    logic signed [31:0] r_o [4];

    lbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_kind     (i_in.kind),
        .i_last     (i_in.last_influence),
        .i_out_busy (r_ovalid && !o_out.ready),
        .o_cmd      (cmd)
    );

    lbs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (i_in.kind),
        .i_bone     (i_in.bone),
        .i_row      (i_in.row),
        .i_a_x      (i_in.a_x),
        .i_a_y      (i_in.a_y),
        .i_a_z      (i_in.a_z),
        .i_a_w      (i_in.a_w),
        .i_weight   (i_in.weight),
        .o_res      (res),
        .o_res_load (res_load)
    );

    // Output register: load on emit, drop valid when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o <= res;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.out_x = r_o[0];
    assign o_out.out_y = r_o[1];
    assign o_out.out_z = r_o[2];
    assign o_out.out_w = r_o[3];

    // Never overwrite a result still waiting at a stalled receiver.
    `LBS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, res_load, !(r_ovalid && !o_out.ready))
    // A sum emit always clears the accumulators.
    `LBS_ASSERT_IMPL(a_emit_clr, i_clk, i_rst_n, cmd.emit_sum, cmd.clr)
    // An emit always shows a valid result next cycle.
    `LBS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, res_load, o_out.valid)
endmodule
`default_nettype wire

// ===== sim/linear_blend_skinning_top_tb.sv =====
`default_nettype none
module linear_blend_skinning_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        lbs_pkg::t_kind kind;
        logic [5:0]  bone;
        logic [1:0]  row;
        logic signed [31:0] ax, ay, az, aw;
        logic [16:0] weight;
        logic        last;
        logic        fixed;   // expected result typed in below
        logic signed [31:0] ex, ey, ez, ew;
    } t_row;

    typedef struct {
        logic signed [31:0] x, y, z, w;
    } t_vec;

    localparam logic signed [31:0] VMAX = 32'sh7fffffff;
    localparam logic signed [31:0] VMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    localparam int LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;
    lbs_in_if  u_in();
    lbs_out_if u_out();

    linear_blend_skinning_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (u_in.sink),
        .o_out  (u_out.source)
    );

    // predictor state
    logic signed [31:0] palette [0:63][0:3][0:3];
    logic signed [63:0] acc [0:3];
    bit   loaded [0:63][0:3];
    t_vec skinned_q[$];
    t_row typed_q[$];     // expectations typed into the table, paired with skinned_q
    int   errors;
    int   results_seen;
    int   cycles;
    bit   stim_done;
    bit   hold_long;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout at %0t", $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic signed [63:0] fl16(input logic signed [127:0] x);
        return 64'(x >>> 16);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sh7fffffff) return VMAX;
        if (x < -64'sh80000000) return VMIN;
        return 32'(x);
    endfunction

    function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7fffffffffffffff) return 64'sh7fffffffffffffff;
        if (s < -65'sh0_8000000000000000) return 64'sh8000000000000000;
        return 64'(s);
    endfunction

    // Advance the predictor by one accepted item; queue the skinned vector if any.
    task automatic skin_predict(input t_row it);
        logic signed [31:0] v [0:3];
        logic signed [63:0] dot;
        logic signed [63:0] term;
        t_vec o;
        v[0] = it.ax; v[1] = it.ay; v[2] = it.az; v[3] = it.aw;
        case (it.kind)
            lbs_pkg::K_LOAD: begin
                for (int c = 0; c < 4; c++) palette[it.bone][it.row][c] = v[c];
                loaded[it.bone][it.row] = 1'b1;
            end
            lbs_pkg::K_PASS: begin
                o.x = it.ax; o.y = it.ay; o.z = it.az; o.w = it.aw;
                skinned_q = {skinned_q, o};
                typed_q = {typed_q, it};
            end
            lbs_pkg::K_INFL: begin
                for (int r = 0; r < 4; r++) begin
                    dot = 0;
                    for (int c = 0; c < 4; c++)
                        dot += fl16(128'(palette[it.bone][r][c]) * 128'(v[c]));
                    dot = 64'(clamp32(dot));
                    term = fl16(128'(dot) * 128'($signed({1'b0, it.weight})));
                    acc[r] = add_sat64(acc[r], term);
                end
                if (it.last) begin
                    o.x = clamp32(acc[0]); o.y = clamp32(acc[1]);
                    o.z = clamp32(acc[2]); o.w = clamp32(acc[3]);
                    for (int r = 0; r < 4; r++) acc[r] = 0;
                    skinned_q = {skinned_q, o};
                    typed_q = {typed_q, it};
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_row mk(input lbs_pkg::t_kind k, input int bone, input int row,
                                input logic signed [31:0] x, y, z, w,
                                input int wt, input bit last);
        t_row r;
        r.kind = k; r.bone = 6'(bone); r.row = 2'(row);
        r.ax = x; r.ay = y; r.az = z; r.aw = w;
        r.weight = 17'(wt); r.last = last; r.fixed = 1'b0;
        r.ex = 0; r.ey = 0; r.ez = 0; r.ew = 0;
        return r;
    endfunction

    function automatic t_row with_result(input t_row r, input logic signed [31:0] x, y, z, w);
        r.fixed = 1'b1; r.ex = x; r.ey = y; r.ez = z; r.ew = w;
        return r;
    endfunction

    t_row stim_tab[$];
    int   sent_items;

    task automatic add_row(input t_row r);
        stim_tab = {stim_tab, r};
    endtask

    // Offer one item; wait for acceptance, holding valid across back-to-back items.
    task automatic offer_item(input t_row it, input int gap);
        if (gap > 0) begin
            u_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        u_in.valid <= 1'b1;
        u_in.kind <= it.kind; u_in.bone <= it.bone; u_in.row <= it.row;
        u_in.a_x <= it.ax; u_in.a_y <= it.ay; u_in.a_z <= it.az; u_in.a_w <= it.aw;
        u_in.weight <= it.weight; u_in.last_influence <= it.last;
        do @(posedge i_clk); while (!u_in.ready);
        skin_predict(it);
        sent_items++;
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return VMAX;
            1: return VMIN;
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic int rnd_weight();
        case ($urandom_range(0, 5))
            0: return 65536;
            1: return 131071;
            2: return 0;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    // Build a random matrix row; values near unity keep most sums in range.
    function automatic t_row rand_load(input int bone, input int row);
        logic signed [31:0] m [0:3];
        for (int c = 0; c < 4; c++)
            m[c] = ($urandom_range(0, 7) == 0) ? rnd32()
                 : 32'($signed($urandom_range(0, 262143)) - 131072);
        return mk(lbs_pkg::K_LOAD, bone, row, m[0], m[1], m[2], m[3], 0,
                  $urandom_range(0, 1));
    endfunction

    task automatic send_bone(input int bone, input bit rand_gap);
        for (int r = 0; r < 4; r++)
            offer_item(rand_load(bone, r), rand_gap ? $urandom_range(0, 3) : 0);
    endtask

    initial begin
        t_row it;
        int b, n;
        errors = 0; results_seen = 0; sent_items = 0;
        stim_done = 1'b0; hold_long = 1'b0;
        for (int r = 0; r < 4; r++) acc[r] = 0;
        foreach (loaded[i, j]) loaded[i][j] = 1'b0;
        u_in.valid = 1'b0; u_in.kind = lbs_pkg::K_LOAD; u_in.bone = 0; u_in.row = 0;
        u_in.a_x = 0; u_in.a_y = 0; u_in.a_z = 0; u_in.a_w = 0;
        u_in.weight = 0; u_in.last_influence = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: extremes, load, influence and passthrough items, saturation, weight above one.
        add_row(with_result(mk(lbs_pkg::K_PASS, 63, 3, VMAX, VMIN, 0, -1, 131071, 1),
                            VMAX, VMIN, 0, -1));
        add_row(with_result(mk(lbs_pkg::K_PASS, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0));
        // identity on bone 0, huge matrix on bone 63
        for (int r = 0; r < 4; r++)
            add_row(mk(lbs_pkg::K_LOAD, 0, r, r == 0 ? ONE : 0, r == 1 ? ONE : 0,
                       r == 2 ? ONE : 0, r == 3 ? ONE : 0, 0, 0));
        for (int r = 0; r < 4; r++)
            add_row(mk(lbs_pkg::K_LOAD, 63, r, VMAX, VMAX, VMIN, VMIN, 131071, 1));
        add_row(with_result(mk(lbs_pkg::K_INFL, 0, 0, ONE, -ONE, 3 * ONE, ONE, 65536, 1),
                            ONE, -ONE, 3 * ONE, ONE));
        add_row(with_result(mk(lbs_pkg::K_INFL, 0, 1, 4 * ONE, 0, 0, 0, 0, 1),
                            0, 0, 0, 0));
        // saturation of dot and of emitted sum; weight above one
        add_row(mk(lbs_pkg::K_INFL, 63, 0, VMAX, VMAX, VMIN, VMIN, 131071, 0));
        add_row(mk(lbs_pkg::K_PASS, 5, 2, 7, -7, VMIN, VMAX, 0, 1)); // inside a vertex
        add_row(mk(lbs_pkg::K_LOAD, 1, 0, ONE, ONE, ONE, ONE, 0, 0)); // sum untouched
        add_row(mk(lbs_pkg::K_INFL, 63, 0, VMIN, VMIN, VMAX, VMAX, 131071, 1));
        add_row(mk(lbs_pkg::K_INFL, 0, 2, ONE, ONE, ONE, ONE, 32768, 0));
        add_row(mk(lbs_pkg::K_INFL, 63, 3, -ONE, 2, -3, ONE, 1, 0));
        add_row(mk(lbs_pkg::K_INFL, 0, 1, VMIN, VMAX, -1, 1, 65535, 1));
        add_row(mk(lbs_pkg::K_INFL, 63, 0, -1, -1, -1, -1, 131071, 1));
        foreach (stim_tab[i]) offer_item(stim_tab[i], $urandom_range(0, 3));

        // Random part: load a few bones, then mostly well-formed vertices.
        for (int bb = 0; bb < 64; bb += $urandom_range(1, 9)) send_bone(bb, 1'b1);
        send_bone(63, 1'b0);
        while (sent_items < 900) begin
            if (sent_items > 500 && sent_items < 520) hold_long = 1'b1;
            case ($urandom_range(0, 9))
                0: send_bone($urandom_range(0, 63), 1'b1);
                1: begin
                    it = mk(lbs_pkg::K_PASS, $urandom_range(0, 63), $urandom_range(0, 3),
                            rnd32(), rnd32(), rnd32(), rnd32(), $urandom_range(0, 131071),
                            $urandom_range(0, 1));
                    offer_item(it, $urandom_range(0, 3));
                end
                default: begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++) begin
                        do b = $urandom_range(0, 63);
                        while (!(loaded[b][0] && loaded[b][1] && loaded[b][2] && loaded[b][3]));
                        it = mk(lbs_pkg::K_INFL, b, $urandom_range(0, 3),
                                rnd32(), rnd32(), rnd32(),
                                $urandom_range(0, 1) ? ONE : 32'(0),
                                rnd_weight(), k == n - 1);
                        if ($urandom_range(0, 3) == 0) it.aw = rnd32();
                        offer_item(it, ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
                    end
                end
            endcase
        end
        u_in.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int stall;
        bit done_long;
        done_long = 1'b0;
        u_out.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long && !done_long) begin
                done_long = 1'b1;
                u_out.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                u_out.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            u_out.ready <= 1'b1;
            do @(posedge i_clk); while (!u_out.valid);
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_vec e;
        t_row tr;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            results_seen++;
            if (skinned_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h %h %h %h", $time,
                         u_out.out_x, u_out.out_y, u_out.out_z, u_out.out_w);
            end else begin
                e = skinned_q.pop_front();
                tr = typed_q.pop_front();
                if (tr.fixed && (tr.ex !== e.x || tr.ey !== e.y ||
                                 tr.ez !== e.z || tr.ew !== e.w)) begin
                    errors++;
                    $display("%0t: table row disagrees: typed %h %h %h %h predicted %h %h %h %h",
                             $time, tr.ex, tr.ey, tr.ez, tr.ew, e.x, e.y, e.z, e.w);
                end
                if (u_out.out_x !== e.x) begin
                    errors++;
                    $display("%0t: out_x expected %h actual %h", $time, e.x, u_out.out_x);
                end
                if (u_out.out_y !== e.y) begin
                    errors++;
                    $display("%0t: out_y expected %h actual %h", $time, e.y, u_out.out_y);
                end
                if (u_out.out_z !== e.z) begin
                    errors++;
                    $display("%0t: out_z expected %h actual %h", $time, e.z, u_out.out_z);
                end
                if (u_out.out_w !== e.w) begin
                    errors++;
                    $display("%0t: out_w expected %h actual %h", $time, e.w, u_out.out_w);
                end
            end
        end
    end

    // Drain, let the pipeline settle, then report.
    initial begin
        wait (stim_done);
        while (skinned_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (skinned_q.size() != 0) errors++;
        $display("run covered %0d input items and %0d skinned or passthrough results",
                 sent_items, results_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== linear_blend_skinning_top.f =====
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_if.sv
sv/lbs_ctrl.sv
sv/lbs_dp.sv
sv/linear_blend_skinning_top.sv
sim/linear_blend_skinning_top_tb.sv
